### hdl/escape_time_fractal_iteration_assert.svh
// Assertion macros shared by the escape-time iteration RTL
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_ASSERT_SVH
`ifndef SYNTHESIS
`define ETF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
`define ETF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");
`else
`define ETF_ASSERT(name, clk, rst_n, prop)
`define ETF_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### hdl/etf_pkg.sv
// Shared constants and types of the escape-time iteration block
package etf_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int FRAC_BITS       = 28;
  localparam int LIMIT_WIDTH     = 3;
  localparam int COUNT_WIDTH     = 12;
  localparam int RING_DEPTH      = 3;
  localparam int TAG_WIDTH       = $clog2(RING_DEPTH);
  localparam int CFG_ADDR_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH  = 12;
  localparam int OUT_TDATA_WIDTH = ((COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ESCAPE_LIMIT   = 1'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MAX_ITERATIONS = 1'd1;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET    = 3'd1;
  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = 12'd127;

  // Control of one ring slot: done slots keep circulating until they retire in order
  typedef struct packed {
    logic                   valid;
    logic                   done;
    logic [TAG_WIDTH-1:0]   tag;
    logic [COUNT_WIDTH-1:0] count;
  } slot_ctrl_t;

endpackage

### hdl/etf_square_stage.sv
// Ring stage one: squares of z for the escape test, and z + c with overflow flag
module etf_square_stage #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  etf_pkg::slot_ctrl_t             ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]   c_re_i,
  input  logic signed [COORD_WIDTH-1:0]   c_im_i,
  input  logic signed [COORD_WIDTH-1:0]   z_re_i,
  input  logic signed [COORD_WIDTH-1:0]   z_im_i,
  output etf_pkg::slot_ctrl_t             ctrl_o,
  output logic signed [COORD_WIDTH-1:0]   c_re_o,
  output logic signed [COORD_WIDTH-1:0]   c_im_o,
  output logic signed [COORD_WIDTH-1:0]   w_re_o,
  output logic signed [COORD_WIDTH-1:0]   w_im_o,
  output logic        [2*COORD_WIDTH-1:0] re_sq_o,
  output logic        [2*COORD_WIDTH-1:0] im_sq_o,
  output logic                            ovf_o
);

  logic signed [2*COORD_WIDTH-1:0] re_sq_d, im_sq_d;
  logic        [COORD_WIDTH:0]     w_re_d, w_im_d;
  logic                            ovf_d;

  etf_pkg::slot_ctrl_t             ctrl_q;
  logic signed [COORD_WIDTH-1:0]   c_re_q, c_im_q, w_re_q, w_im_q;
  logic        [2*COORD_WIDTH-1:0] re_sq_q, im_sq_q;
  logic                            ovf_q;

  assign re_sq_d = z_re_i * z_re_i;
  assign im_sq_d = z_im_i * z_im_i;
  assign w_re_d  = {c_re_i[COORD_WIDTH-1], c_re_i} + {z_re_i[COORD_WIDTH-1], z_re_i};
  assign w_im_d  = {c_im_i[COORD_WIDTH-1], c_im_i} + {z_im_i[COORD_WIDTH-1], z_im_i};
  // top two bits of the widened sum disagree when z + c leaves the coordinate range
  assign ovf_d   = (w_re_d[COORD_WIDTH] != w_re_d[COORD_WIDTH-1]) ||
                   (w_im_d[COORD_WIDTH] != w_im_d[COORD_WIDTH-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_re_q  <= c_re_i;
    c_im_q  <= c_im_i;
    w_re_q  <= $signed(w_re_d[COORD_WIDTH-1:0]);
    w_im_q  <= $signed(w_im_d[COORD_WIDTH-1:0]);
    re_sq_q <= re_sq_d;
    im_sq_q <= im_sq_d;
    ovf_q   <= ovf_d;
  end

  assign ctrl_o  = ctrl_q;
  assign c_re_o  = c_re_q;
  assign c_im_o  = c_im_q;
  assign w_re_o  = w_re_q;
  assign w_im_o  = w_im_q;
  assign re_sq_o = re_sq_q;
  assign im_sq_o = im_sq_q;
  assign ovf_o   = ovf_q;

endmodule

### hdl/etf_test_stage.sv
// Ring stage two: escape and bound test, count update, products of z + c
module etf_test_stage #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = etf_pkg::FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  etf_pkg::slot_ctrl_t                     ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]           c_re_i,
  input  logic signed [COORD_WIDTH-1:0]           c_im_i,
  input  logic signed [COORD_WIDTH-1:0]           w_re_i,
  input  logic signed [COORD_WIDTH-1:0]           w_im_i,
  input  logic        [2*COORD_WIDTH-1:0]         re_sq_i,
  input  logic        [2*COORD_WIDTH-1:0]         im_sq_i,
  input  logic                                    ovf_i,
  input  logic        [etf_pkg::LIMIT_WIDTH-1:0]  limit_i,
  input  logic        [etf_pkg::COUNT_WIDTH-1:0]  max_iter_i,
  output etf_pkg::slot_ctrl_t                     ctrl_o,
  output logic signed [COORD_WIDTH-1:0]           c_re_o,
  output logic signed [COORD_WIDTH-1:0]           c_im_o,
  output logic signed [2*COORD_WIDTH-1:0]         p_re_o,
  output logic signed [2*COORD_WIDTH-1:0]         p_im_o,
  output logic signed [2*COORD_WIDTH-1:0]         p_cross_o
);

  // wide enough for |z|^2 and for limit^2 placed at the product's binary point
  localparam int CMP_W = (2 * COORD_WIDTH > 2 * FRAC_BITS + 2 * etf_pkg::LIMIT_WIDTH) ?
                         2 * COORD_WIDTH : 2 * FRAC_BITS + 2 * etf_pkg::LIMIT_WIDTH;

  logic [2*etf_pkg::LIMIT_WIDTH-1:0] lim_sq;
  logic [CMP_W-1:0]                  mag_sum, bound;
  logic                              go;
  etf_pkg::slot_ctrl_t               ctrl_d;
  logic signed [2*COORD_WIDTH-1:0]   p_re_d, p_im_d, p_cross_d;

  etf_pkg::slot_ctrl_t               ctrl_q;
  logic signed [COORD_WIDTH-1:0]     c_re_q, c_im_q;
  logic signed [2*COORD_WIDTH-1:0]   p_re_q, p_im_q, p_cross_q;

  assign lim_sq  = limit_i * limit_i;
  assign bound   = CMP_W'(lim_sq) << (2 * FRAC_BITS);
  assign mag_sum = CMP_W'(re_sq_i) + CMP_W'(im_sq_i);
  assign go      = (mag_sum <= bound) && (ctrl_i.count < max_iter_i);

  always_comb begin
    ctrl_d = ctrl_i;
    if (ctrl_i.valid && !ctrl_i.done) begin
      if (go) begin
        ctrl_d.count = ctrl_i.count + 1'b1;
        ctrl_d.done  = ovf_i;
      end else begin
        ctrl_d.done = 1'b1;
      end
    end
  end

  assign p_re_d    = w_re_i * w_re_i;
  assign p_im_d    = w_im_i * w_im_i;
  assign p_cross_d = w_re_i * w_im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_re_q    <= c_re_i;
    c_im_q    <= c_im_i;
    p_re_q    <= p_re_d;
    p_im_q    <= p_im_d;
    p_cross_q <= p_cross_d;
  end

  assign ctrl_o    = ctrl_q;
  assign c_re_o    = c_re_q;
  assign c_im_o    = c_im_q;
  assign p_re_o    = p_re_q;
  assign p_im_o    = p_im_q;
  assign p_cross_o = p_cross_q;

endmodule

### hdl/etf_update_stage.sv
// Ring stage three: new z from the products, rescale and range check
module etf_update_stage #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = etf_pkg::FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  etf_pkg::slot_ctrl_t             ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]   c_re_i,
  input  logic signed [COORD_WIDTH-1:0]   c_im_i,
  input  logic signed [2*COORD_WIDTH-1:0] p_re_i,
  input  logic signed [2*COORD_WIDTH-1:0] p_im_i,
  input  logic signed [2*COORD_WIDTH-1:0] p_cross_i,
  output etf_pkg::slot_ctrl_t             ctrl_o,
  output logic signed [COORD_WIDTH-1:0]   c_re_o,
  output logic signed [COORD_WIDTH-1:0]   c_im_o,
  output logic signed [COORD_WIDTH-1:0]   z_re_o,
  output logic signed [COORD_WIDTH-1:0]   z_im_o
);

  logic signed [2*COORD_WIDTH:0]    re_full, im_full, re_sh, im_sh;
  logic        [COORD_WIDTH+1:0]    re_top, im_top;
  logic                             fits;
  etf_pkg::slot_ctrl_t              ctrl_d;

  etf_pkg::slot_ctrl_t              ctrl_q;
  logic signed [COORD_WIDTH-1:0]    c_re_q, c_im_q, z_re_q, z_im_q;

  assign re_full = $signed({p_re_i[2*COORD_WIDTH-1], p_re_i}) -
                   $signed({p_im_i[2*COORD_WIDTH-1], p_im_i});
  assign im_full = $signed({p_cross_i, 1'b0});
  // floor division by 2^FRAC_BITS
  assign re_sh   = re_full >>> FRAC_BITS;
  assign im_sh   = im_full >>> FRAC_BITS;
  assign re_top  = re_sh[2*COORD_WIDTH:COORD_WIDTH-1];
  assign im_top  = im_sh[2*COORD_WIDTH:COORD_WIDTH-1];
  assign fits    = ((&re_top) || (~|re_top)) && ((&im_top) || (~|im_top));

  always_comb begin
    ctrl_d = ctrl_i;
    if (ctrl_i.valid && !ctrl_i.done && !fits) begin
      ctrl_d.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_re_q <= c_re_i;
    c_im_q <= c_im_i;
    z_re_q <= re_sh[COORD_WIDTH-1:0];
    z_im_q <= im_sh[COORD_WIDTH-1:0];
  end

  assign ctrl_o = ctrl_q;
  assign c_re_o = c_re_q;
  assign c_im_o = c_im_q;
  assign z_re_o = z_re_q;
  assign z_im_o = z_im_q;

endmodule

### hdl/escape_time_fractal_iteration.sv
// Escape-time iteration of z = (z + c)^2 on a three-stage ring; up to three points in flight.
// Each ring pass is one iteration of one point; three points share the ring, and a new point
//   is taken into a free slot while older points still iterate; results leave in input order.
// Reset: asynchronous, active low; empties the ring and output, escape_limit 1, max_iterations 127.
`include "escape_time_fractal_iteration_assert.svh"

module escape_time_fractal_iteration #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = etf_pkg::FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [etf_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr_i,
  input  logic [etf_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // c_re, c_im
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // iteration_count
  output logic [etf_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata_o
);

  localparam int TW = etf_pkg::TAG_WIDTH;
  localparam logic [TW-1:0] TAG_LAST = TW'(etf_pkg::RING_DEPTH - 1);

  logic [etf_pkg::LIMIT_WIDTH-1:0] limit_q;
  logic [etf_pkg::COUNT_WIDTH-1:0] max_iter_q;

  logic [TW-1:0] in_tag_q, in_tag_d, head_q, head_d;
  logic                            out_valid_q, out_valid_d;
  logic [etf_pkg::COUNT_WIDTH-1:0] out_count_q, out_count_d;

  etf_pkg::slot_ctrl_t s0_ctrl, s1_ctrl, s2_ctrl, s3_ctrl;
  logic signed [COORD_WIDTH-1:0] s0_c_re, s0_c_im, s0_z_re, s0_z_im;
  logic signed [COORD_WIDTH-1:0] s1_c_re, s1_c_im, s1_w_re, s1_w_im;
  logic        [2*COORD_WIDTH-1:0] s1_re_sq, s1_im_sq;
  logic                          s1_ovf;
  logic signed [COORD_WIDTH-1:0] s2_c_re, s2_c_im;
  logic signed [2*COORD_WIDTH-1:0] s2_p_re, s2_p_im, s2_p_cross;
  logic signed [COORD_WIDTH-1:0] s3_c_re, s3_c_im, s3_z_re, s3_z_im;

  logic retire, accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= etf_pkg::LIMIT_RESET;
      max_iter_q <= etf_pkg::MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        etf_pkg::CFG_ESCAPE_LIMIT:   limit_q    <= cfg_wdata_i[etf_pkg::LIMIT_WIDTH-1:0];
        etf_pkg::CFG_MAX_ITERATIONS: max_iter_q <= cfg_wdata_i[etf_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // oldest point leaves the ring once finished and the output register is empty or being read
  assign retire = s3_ctrl.valid && s3_ctrl.done && (s3_ctrl.tag == head_q) &&
                  (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s3_ctrl.valid || retire;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s0_c_re = s3_c_re;
    s0_c_im = s3_c_im;
    s0_z_re = s3_z_re;
    s0_z_im = s3_z_im;
    s0_ctrl = '0;
    if (s3_ctrl.valid && !retire) begin
      s0_ctrl = s3_ctrl;
    end else if (accept) begin
      s0_ctrl.valid = 1'b1;
      s0_ctrl.tag   = in_tag_q;
      s0_c_re = $signed(s_axis_tdata_i[COORD_WIDTH-1:0]);
      s0_c_im = $signed(s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]);
      s0_z_re = '0;
      s0_z_im = '0;
    end
  end

  assign in_tag_d = !accept ? in_tag_q : (in_tag_q == TAG_LAST) ? '0 : in_tag_q + 1'b1;
  assign head_d   = !retire ? head_q : (head_q == TAG_LAST) ? '0 : head_q + 1'b1;

  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (retire) begin
      out_valid_d = 1'b1;
      out_count_d = (s3_ctrl.count == '0) ? '0 : s3_ctrl.count - 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q    <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_tag_q    <= in_tag_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = etf_pkg::OUT_TDATA_WIDTH'(out_count_q);

  etf_square_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (s0_ctrl),
    .c_re_i  (s0_c_re),
    .c_im_i  (s0_c_im),
    .z_re_i  (s0_z_re),
    .z_im_i  (s0_z_im),
    .ctrl_o  (s1_ctrl),
    .c_re_o  (s1_c_re),
    .c_im_o  (s1_c_im),
    .w_re_o  (s1_w_re),
    .w_im_o  (s1_w_im),
    .re_sq_o (s1_re_sq),
    .im_sq_o (s1_im_sq),
    .ovf_o   (s1_ovf)
  );

  etf_test_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_test (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (s1_ctrl),
    .c_re_i     (s1_c_re),
    .c_im_i     (s1_c_im),
    .w_re_i     (s1_w_re),
    .w_im_i     (s1_w_im),
    .re_sq_i    (s1_re_sq),
    .im_sq_i    (s1_im_sq),
    .ovf_i      (s1_ovf),
    .limit_i    (limit_q),
    .max_iter_i (max_iter_q),
    .ctrl_o     (s2_ctrl),
    .c_re_o     (s2_c_re),
    .c_im_o     (s2_c_im),
    .p_re_o     (s2_p_re),
    .p_im_o     (s2_p_im),
    .p_cross_o  (s2_p_cross)
  );

  etf_update_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (s2_ctrl),
    .c_re_i    (s2_c_re),
    .c_im_i    (s2_c_im),
    .p_re_i    (s2_p_re),
    .p_im_i    (s2_p_im),
    .p_cross_i (s2_p_cross),
    .ctrl_o    (s3_ctrl),
    .c_re_o    (s3_c_re),
    .c_im_o    (s3_c_im),
    .z_re_o    (s3_z_re),
    .z_im_o    (s3_z_im)
  );

  `ETF_ASSERT(a_count_below_max, clk_i, rst_ni, m_axis_tvalid_o |-> (out_count_q != '1))
  `ETF_ASSERT(a_done_kept, clk_i, rst_ni, (s2_ctrl.valid && s2_ctrl.done) |=> (s3_ctrl.valid && s3_ctrl.done))
  `ETF_ASSERT(a_no_slot_lost, clk_i, rst_ni, (s3_ctrl.valid && !retire) |=> s1_ctrl.valid)
  `ETF_ASSERT(a_entry_fresh, clk_i, rst_ni, accept |=> (s1_ctrl.valid && !s1_ctrl.done && (s1_ctrl.count == '0)))
  `ETF_ASSERT_ALWAYS(a_reset_clears_out, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

### tb/escape_time_fractal_iteration_checker.sv
// Stream checker for the escape-time iteration block: predicts and compares iteration counts
module escape_time_fractal_iteration_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [etf_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr_i,
  input  logic [etf_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata_i,
  input  logic                                 s_tvalid_i,
  input  logic                                 s_tready_i,
  // c_re, c_im
  input  logic [2*etf_pkg::COORD_WIDTH-1:0]    s_tdata_i,
  input  logic                                 m_tvalid_i,
  input  logic                                 m_tready_i,
  // iteration_count
  input  logic [etf_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o
);

  localparam int WIDE = 4 * etf_pkg::COORD_WIDTH;
  localparam logic signed [WIDE-1:0] COORD_TOP =
    {{(WIDE-etf_pkg::COORD_WIDTH+1){1'b0}}, {(etf_pkg::COORD_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE-1:0] COORD_BOT = ~COORD_TOP;

  logic [etf_pkg::LIMIT_WIDTH-1:0] escape_limit_q;
  logic [etf_pkg::COUNT_WIDTH-1:0] max_iter_q;
  logic [etf_pkg::COUNT_WIDTH-1:0] expected_counts[$];
  logic [etf_pkg::COUNT_WIDTH-1:0] actual_count, wanted_count;

  function automatic bit fits_coord(input logic signed [WIDE-1:0] v);
    return (v >= COORD_BOT) && (v <= COORD_TOP);
  endfunction

  // z starts at 0; each pass: z += c, z = z^2, exact products, floor on the shift back
  function automatic logic [etf_pkg::COUNT_WIDTH-1:0] predict_escape_count(
    input logic signed [etf_pkg::COORD_WIDTH-1:0] c_re,
    input logic signed [etf_pkg::COORD_WIDTH-1:0] c_im,
    input logic [etf_pkg::LIMIT_WIDTH-1:0]        limit,
    input logic [etf_pkg::COUNT_WIDTH-1:0]        max_iter
  );
    logic signed [WIDE-1:0] cr, ci, zr, zi, nr, ni, bound, lim_w;
    int unsigned iters;
    cr = c_re;
    ci = c_im;
    zr = '0;
    zi = '0;
    iters = 0;
    lim_w = {{(WIDE-etf_pkg::LIMIT_WIDTH){1'b0}}, limit};
    bound = (lim_w * lim_w) <<< (2 * etf_pkg::FRAC_BITS);
    while ((zr * zr + zi * zi <= bound) && (iters < max_iter)) begin
      iters++;
      zr = zr + cr;
      zi = zi + ci;
      if (!fits_coord(zr) || !fits_coord(zi)) break;
      nr = (zr * zr - zi * zi) >>> etf_pkg::FRAC_BITS;
      ni = ((zr * zi) <<< 1) >>> etf_pkg::FRAC_BITS;
      // overflow of the square counts as escape, this pass included
      if (!fits_coord(nr) || !fits_coord(ni)) break;
      zr = nr;
      zi = ni;
    end
    return (iters == 0) ? '0 : etf_pkg::COUNT_WIDTH'(iters - 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_limit_q = etf_pkg::LIMIT_RESET;
      max_iter_q     = etf_pkg::MAX_ITER_RESET;
      expected_counts.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        actual_count = m_tdata_i[etf_pkg::COUNT_WIDTH-1:0];
        checked_o++;
        if (expected_counts.size() == 0) begin
          $error("iteration_count: expected none, actual %0d", actual_count);
          fail_count_o++;
        end else begin
          wanted_count = expected_counts.pop_front();
          if (wanted_count !== actual_count) begin
            $error("iteration_count: expected %0d, actual %0d", wanted_count, actual_count);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_counts.push_back(predict_escape_count(
          s_tdata_i[etf_pkg::COORD_WIDTH-1:0],
          s_tdata_i[2*etf_pkg::COORD_WIDTH-1:etf_pkg::COORD_WIDTH],
          escape_limit_q, max_iter_q));
      if (cfg_we_i) begin
        if (cfg_addr_i == etf_pkg::CFG_ESCAPE_LIMIT)
          escape_limit_q = cfg_wdata_i[etf_pkg::LIMIT_WIDTH-1:0];
        else if (cfg_addr_i == etf_pkg::CFG_MAX_ITERATIONS)
          max_iter_q = cfg_wdata_i[etf_pkg::COUNT_WIDTH-1:0];
      end
    end
    pending_o = expected_counts.size();
  end

endmodule

### tb/escape_time_fractal_iteration_tb.sv
// Top of the escape-time iteration testbench: clock, reset, stimulus and verdict
module escape_time_fractal_iteration_tb;

  localparam longint TIMEOUT_CYCLES = 4_000_000;

  typedef enum int {SPAN_FULL, SPAN_EXTREME, SPAN_CORE, SPAN_NEAR} span_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [etf_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [etf_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata;
  logic s_valid, s_ready;
  logic [2*etf_pkg::COORD_WIDTH-1:0] s_data;
  logic m_valid, m_ready;
  logic [etf_pkg::OUT_TDATA_WIDTH-1:0] m_data;

  int fail_count, pending, checked;
  int settings_used = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  always #4 clk = ~clk;

  escape_time_fractal_iteration u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  escape_time_fractal_iteration_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // mostly back-to-back or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [etf_pkg::COORD_WIDTH-1:0] random_coord(input span_e span);
    logic [etf_pkg::COORD_WIDTH-1:0] v;
    case (span)
      SPAN_FULL: v = $urandom();
      SPAN_EXTREME: begin
        case ($urandom_range(0, 6))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h1000_0000;
          5: v = 32'hF000_0000;
          default: v = 32'h2000_0000;
        endcase
      end
      // within +-0.25: these tend to run to the iteration bound
      SPAN_CORE: v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      default:   v = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endcase
    return v;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_point(input logic [etf_pkg::COORD_WIDTH-1:0] re,
                            input logic [etf_pkg::COORD_WIDTH-1:0] im);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {im, re};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_point();
    int r;
    span_e span;
    r = $urandom_range(0, 99);
    if (r < 15) span = SPAN_FULL;
    else if (r < 25) span = SPAN_EXTREME;
    else if (r < 55) span = SPAN_CORE;
    else span = SPAN_NEAR;
    send_point(random_coord(span), random_coord(span));
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_config(input int limit, input int max_iter);
    cfg_we    <= 1'b1;
    cfg_addr  <= etf_pkg::CFG_ESCAPE_LIMIT;
    cfg_wdata <= etf_pkg::CFG_DATA_WIDTH'(limit);
    @(negedge clk);
    cfg_addr  <= etf_pkg::CFG_MAX_ITERATIONS;
    cfg_wdata <= etf_pkg::CFG_DATA_WIDTH'(max_iter);
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int limit, input int max_iter, input int n_points,
                           input bit steady_mode);
    wait_idle();
    set_config(limit, max_iter);
    steady = steady_mode;
    repeat (n_points) send_random_point();
  endtask

  // result side: random ready pattern, plus one long hold-off on request
  initial begin
    int run_left, hold_left;
    m_ready = 1'b0;
    run_left = 0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else if (steady || $urandom_range(0, 99) < 55) begin
        m_ready <= 1'b1;
        run_left = $urandom_range(0, steady ? 15 : 7);
      end else begin
        m_ready <= 1'b0;
        run_left = $urandom_range(0, 99) < 80 ? $urandom_range(0, 2) :
                   ($urandom_range(0, 99) < 80 ? $urandom_range(3, 10) :
                    $urandom_range(20, 80));
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("FAIL");
    $finish;
  end

  initial begin
    s_valid   = 1'b0;
    s_data    = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: limit 1, 127 iterations
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h1000_0000, 32'h0000_0000);
    send_point(32'hF000_0000, 32'h0000_0000);  // lands exactly on the bound every second pass
    send_point(32'h0000_0000, 32'hF000_0000);
    send_point(32'h0000_0000, 32'h1000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // tiny square floors to zero
    send_point(32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'h0010_0000, 32'h0020_0000);
    send_point(32'h2000_0000, 32'h0000_0000);
    send_point(32'hC000_0000, 32'h0000_0000);  // square leaves the coordinate range
    send_point(32'h0800_0000, 32'h0800_0000);
    send_point(32'hF800_0000, 32'h0000_0000);
    send_point(32'h2D41_3CCD, 32'h0000_0000);  // square sits at the range edge
    send_point(32'h0000_0000, 32'h2D41_3CCD);

    run_phase(7, 4095, 6, 1'b0);
    run_phase(0, 0, 40, 1'b0);
    run_phase(0, 20, 100, 1'b0);
    run_phase(1, 1, 80, 1'b1);
    wait_idle();
    set_config(2, 127);
    steady = 1'b0;
    hold_req = 1'b1;
    repeat (300) send_random_point();
    run_phase(7, 63, 250, 1'b1);
    run_phase(4, 255, 150, 1'b0);
    run_phase(3, 100, 250, 1'b0);
    run_phase(5, 4095, 4, 1'b0);
    run_phase(6, 31, 200, 1'b0);
    run_phase(2, 127, 200, 1'b0);
    run_phase($urandom_range(0, 7), $urandom_range(1, 200), 100, 1'b0);

    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("Checked %0d iteration counts over %0d register settings.", checked,
             settings_used + 1);
    $display("Limits 0 to 7, bounds 0 to 4095, overflow and exact-bound points included.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
